// ===== design/great_circle_distance_macros.svh =====
// Assertion macros for the great-circle distance block.
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH
`ifndef SYNTH
`define GCD_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("gcd: implication failed");
`define GCD_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("gcd: forbidden condition");
`else
`define GCD_IMPLIES(lbl, ante, cons)
`define GCD_NEVER(lbl, expr)
`endif
`endif

// ===== design/gcd_pkg.sv =====
// Constants and elaboration helpers for the great-circle distance block.
package gcd_pkg;
	localparam int CORDIC_STEPS_DEF    = 32;
	localparam int ANGLE_FRAC_BITS_DEF = 30;

	localparam logic [63:0] RAD_PER_UNIT_Q93 = 64'd17284903702238200000;
	localparam logic [63:0] PI_Q62           = 64'hC90FDAA22168C235;
	localparam logic [63:0] QUARTER_PI_Q62   = 64'h3243F6A8885A308D;
	localparam logic [63:0] GAIN_INV_Q62     = 64'd2800459869988536347;

	localparam logic [30:0] HALF_CIRC_CM = 31'd2001508680;
	localparam logic [30:0] DIAM_CM      = 31'd1274200000;

	localparam logic signed [32:0] FULL_TURN = 33'sd3600000000;
	localparam logic signed [32:0] HALF_TURN = 33'sd1800000000;

	function automatic logic [63:0] atan_q62(input int unsigned i);
		logic [63:0] acc;
		logic [63:0] num;
		logic [63:0] quo;
		logic [63:0] rem;
		int unsigned k;
		int unsigned b;
		logic neg;
		if (i == 0) begin
			return QUARTER_PI_Q62;
		end
		acc = '0;
		neg = 1'b0;
		for (k = 1; i * k <= 62; k += 2) begin
			num = 64'd1 << (62 - i * k);
			quo = '0;
			rem = '0;
			for (b = 0; b < 64; b++) begin
				rem = {rem[62:0], num[63 - b]};
				quo = quo << 1;
				if (rem >= 64'(k)) begin
					rem = rem - 64'(k);
					quo[0] = 1'b1;
				end
			end
			acc = neg ? acc - quo : acc + quo;
			neg = !neg;
		end
		return acc;
	endfunction
endpackage

// ===== design/great_circle_distance.sv =====
// Pipelined haversine great-circle distance between two points.
//
//  channel   signals                                        dir
//  request   start, start_lat/lon, end_lat/lon (busy out)   in
//  result    done, distance_cm                               out
//
// One request enters every cycle; busy stays low.
// The pipeline runs through the two CORDIC chains (one step per stage) and
// the bit-serial square root stages.
// Reset clears only the valid chain; the datapath needs no reset.
// The result is shown for one cycle with done high; nothing holds it.
module great_circle_distance #(
	parameter int CORDIC_STEPS    = gcd_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] start_lat,
	input  logic signed [31:0] start_lon,
	input  logic signed [30:0] end_lat,
	input  logic signed [31:0] end_lon,
	output logic               done,
	output logic        [30:0] distance_cm
);
	import gcd_pkg::*;

	localparam int N   = CORDIC_STEPS;
	localparam int F   = ANGLE_FRAC_BITS;
	localparam int W   = F + 4;
	localparam int M   = W - 1;
	localparam int ML  = (M + 1) / 2;
	localparam int MH  = M - ML;
	localparam int SPW = 2 * M + 2;
	localparam int D   = F + 1;
	localparam int LAT = 11 + 2 * N + D;

	function automatic logic signed [W-1:0] q62f(input logic [63:0] v);
		logic [63:0] t;
		t = (v + (64'd1 << (61 - F))) >> (62 - F);
		return W'(t);
	endfunction

	localparam logic signed [W-1:0] GAIN_F    = q62f(GAIN_INV_Q62);
	localparam logic signed [W-1:0] PI_F      = q62f(PI_Q62);
	localparam logic signed [W-1:0] HALF_PI_F = q62f(PI_Q62 >> 1);
	localparam logic signed [W:0]   ONE_F     = (W+1)'(1) << F;

	typedef struct packed {
		logic [2*ML-1:0] ll;
		logic [2*ML-1:0] lh;
		logic [2*ML-1:0] hl;
		logic [2*ML-1:0] hh;
		logic            neg;
	} pp_t;

	function automatic logic [M-1:0] mag(input logic signed [W-1:0] v);
		logic signed [W-1:0] n;
		n = -v;
		return v[W-1] ? n[M-1:0] : v[M-1:0];
	endfunction

	function automatic pp_t mul_pp(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic [M-1:0] ma;
		logic [M-1:0] mb;
		logic [ML-1:0] al;
		logic [ML-1:0] ah;
		logic [ML-1:0] bl;
		logic [ML-1:0] bh;
		pp_t p;
		ma = mag(a);
		mb = mag(b);
		al = ma[ML-1:0];
		bl = mb[ML-1:0];
		ah = ML'(ma[M-1:ML]);
		bh = ML'(mb[M-1:ML]);
		p.ll = al * bl;
		p.lh = al * bh;
		p.hl = ah * bl;
		p.hh = ah * bh;
		p.neg = a[W-1] ^ b[W-1];
		return p;
	endfunction

	function automatic logic signed [W-1:0] mul_fin(input pp_t p);
		logic [SPW-1:0] sum;
		logic signed [W-1:0] r;
		sum = (SPW'(p.hh) << (2 * ML)) + ((SPW'(p.lh) + SPW'(p.hl)) << ML)
			+ SPW'(p.ll) + (SPW'(1) << (F - 1));
		r = W'(sum >> F);
		return p.neg ? -r : r;
	endfunction

	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	// stage 1: differences and longitude wrap
	logic signed [32:0] dlon_c;
	logic signed [32:0] dlon_w;
	logic signed [31:0] lat1_s1, lat2_s1, dlat_s1, dlon_s1;

	always_comb begin
		dlon_c = 33'(end_lon) - 33'(start_lon);
		if (dlon_c > HALF_TURN) begin
			dlon_w = dlon_c - FULL_TURN;
		end else if (dlon_c <= -HALF_TURN) begin
			dlon_w = dlon_c + FULL_TURN;
		end else begin
			dlon_w = dlon_c;
		end
	end

	always_ff @(posedge clk) begin
		lat1_s1 <= 32'(start_lat);
		lat2_s1 <= 32'(end_lat);
		dlat_s1 <= 32'(end_lat) - 32'(start_lat);
		dlon_s1 <= dlon_w[31:0];
	end

	logic signed [31:0] deg_c [4];
	assign deg_c[0] = lat1_s1;
	assign deg_c[1] = lat2_s1;
	assign deg_c[2] = dlat_s1;
	assign deg_c[3] = dlon_s1;

	logic [63:0]         pl_s2 [4];
	logic [63:0]         ph_s2 [4];
	logic                neg_s2 [4];
	logic signed [W-1:0] ang_s3 [4];
	logic signed [W-1:0] th_s4 [4];
	logic                flip_s4 [4];
	logic signed [W-1:0] rx_s [4][N];
	logic signed [W-1:0] ry_s [4][N];
	logic signed [W-1:0] rz_s [4][N];
	logic                rf_s [4][N];
	logic signed [W-1:0] cosv [4];

	for (genvar j = 0; j < 4; j++) begin : g_lane
		localparam int S = 93 - F + ((j >= 2) ? 1 : 0);
		logic [31:0] dm;
		logic [95:0] sum;
		logic [95:0] shv;
		logic signed [W-1:0] am;

		assign dm  = deg_c[j][31] ? -deg_c[j] : deg_c[j];
		assign sum = {ph_s2[j], 32'd0} + 96'(pl_s2[j]) + (96'd1 << (S - 1));
		assign shv = sum >> S;
		assign am  = W'(shv);

		always_ff @(posedge clk) begin
			pl_s2[j]  <= 64'(dm) * 64'(RAD_PER_UNIT_Q93[31:0]);
			ph_s2[j]  <= 64'(dm) * 64'(RAD_PER_UNIT_Q93[63:32]);
			neg_s2[j] <= deg_c[j][31];
			ang_s3[j] <= neg_s2[j] ? -am : am;
			if (ang_s3[j] > HALF_PI_F) begin
				th_s4[j]   <= PI_F - ang_s3[j];
				flip_s4[j] <= 1'b1;
			end else if (ang_s3[j] < -HALF_PI_F) begin
				th_s4[j]   <= -PI_F - ang_s3[j];
				flip_s4[j] <= 1'b1;
			end else begin
				th_s4[j]   <= ang_s3[j];
				flip_s4[j] <= 1'b0;
			end
		end

		for (genvar i = 0; i < N; i++) begin : g_rot
			localparam logic signed [W-1:0] A = q62f(atan_q62(i));
			logic signed [W-1:0] xi, yi, zi;
			logic fi;
			if (i == 0) begin : g_first
				assign xi = GAIN_F;
				assign yi = '0;
				assign zi = th_s4[j];
				assign fi = flip_s4[j];
			end else begin : g_next
				assign xi = rx_s[j][i-1];
				assign yi = ry_s[j][i-1];
				assign zi = rz_s[j][i-1];
				assign fi = rf_s[j][i-1];
			end
			always_ff @(posedge clk) begin
				rf_s[j][i] <= fi;
				if (!zi[W-1]) begin
					rx_s[j][i] <= xi - (yi >>> i);
					ry_s[j][i] <= yi + (xi >>> i);
					rz_s[j][i] <= zi - A;
				end else begin
					rx_s[j][i] <= xi + (yi >>> i);
					ry_s[j][i] <= yi - (xi >>> i);
					rz_s[j][i] <= zi + A;
				end
			end
		end

		assign cosv[j] = rf_s[j][N-1] ? -rx_s[j][N-1] : rx_s[j][N-1];
	end

	// stages 5..9: the haversine term
	pp_t                 pp1_s5, pp2_s5, pp3_s5, pp4_s7;
	logic signed [W-1:0] q1_s6, q2_s6, q3_s6, q1_s7, q1_s8, q4_s8;
	logic signed [W:0]   asum;
	logic        [D-1:0] a_s9, b_s9;

	assign asum = (W+1)'(q1_s8) + (W+1)'(q4_s8);

	always_ff @(posedge clk) begin
		pp1_s5 <= mul_pp(ry_s[2][N-1], ry_s[2][N-1]);
		pp2_s5 <= mul_pp(cosv[0], cosv[1]);
		pp3_s5 <= mul_pp(ry_s[3][N-1], ry_s[3][N-1]);
		q1_s6  <= mul_fin(pp1_s5);
		q2_s6  <= mul_fin(pp2_s5);
		q3_s6  <= mul_fin(pp3_s5);
		pp4_s7 <= mul_pp(q2_s6, q3_s6);
		q1_s7  <= q1_s6;
		q4_s8  <= mul_fin(pp4_s7);
		q1_s8  <= q1_s7;
		if (asum[W]) begin
			a_s9 <= '0;
			b_s9 <= D'(ONE_F);
		end else if (asum > ONE_F) begin
			a_s9 <= D'(ONE_F);
			b_s9 <= '0;
		end else begin
			a_s9 <= D'(asum);
			b_s9 <= D'(ONE_F - asum);
		end
	end

	// square roots, two radicand bits per stage
	logic [2*D-1:0] rt_s [2][D];
	logic [D-1:0]   rr_s [2][D];
	logic [D+1:0]   rm_s [2][D];

	for (genvar q = 0; q < 2; q++) begin : g_root
		for (genvar k = 0; k < D; k++) begin : g_dig
			logic [2*D-1:0] ti;
			logic [D-1:0]   ri;
			logic [D+1:0]   mi, msh, trial;
			if (k == 0) begin : g_first
				assign ti = (2*D)'(q == 0 ? a_s9 : b_s9) << F;
				assign ri = '0;
				assign mi = '0;
			end else begin : g_next
				assign ti = rt_s[q][k-1];
				assign ri = rr_s[q][k-1];
				assign mi = rm_s[q][k-1];
			end
			assign msh   = {mi[D-1:0], ti[2*D-1-2*k -: 2]};
			assign trial = {ri, 2'b01};
			always_ff @(posedge clk) begin
				rt_s[q][k] <= ti;
				if (msh >= trial) begin
					rm_s[q][k] <= msh - trial;
					rr_s[q][k] <= {ri[D-2:0], 1'b1};
				end else begin
					rm_s[q][k] <= msh;
					rr_s[q][k] <= {ri[D-2:0], 1'b0};
				end
			end
		end
	end

	// vectoring CORDIC for the central angle
	logic signed [W-1:0] vx_s [N];
	logic signed [W-1:0] vy_s [N];
	logic signed [W-1:0] vz_s [N];

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [W-1:0] A = q62f(atan_q62(i));
		logic signed [W-1:0] xi, yi, zi;
		if (i == 0) begin : g_first
			assign xi = W'(rr_s[1][D-1]);
			assign yi = W'(rr_s[0][D-1]);
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_s[i-1];
			assign yi = vy_s[i-1];
			assign zi = vz_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (!yi[W-1]) begin
				vx_s[i] <= xi + (yi >>> i);
				vy_s[i] <= yi - (xi >>> i);
				vz_s[i] <= zi + A;
			end else begin
				vx_s[i] <= xi - (yi >>> i);
				vy_s[i] <= yi + (xi >>> i);
				vz_s[i] <= zi - A;
			end
		end
	end

	// scale to centimetres and saturate
	logic [M-1:0]      zc;
	logic [ML+30:0]    zl_s10, zh_s10;
	logic [M+31:0]     dsum;
	logic [M+31-F:0]   dsh;

	assign zc   = vz_s[N-1][W-1] ? '0 : vz_s[N-1][M-1:0];
	assign dsum = ((M+32)'(zh_s10) << ML) + (M+32)'(zl_s10) + ((M+32)'(1) << (F - 1));
	assign dsh  = dsum[M+31:F];

	always_ff @(posedge clk) begin
		zl_s10 <= (ML+31)'(zc[ML-1:0]) * (ML+31)'(DIAM_CM);
		zh_s10 <= (ML+31)'(zc[M-1:ML]) * (ML+31)'(DIAM_CM);
		if (dsh > (M+32-F)'(HALF_CIRC_CM)) begin
			distance_cm <= HALF_CIRC_CM;
		end else begin
			distance_cm <= dsh[30:0];
		end
	end

	`include "great_circle_distance_macros.svh"

	`GCD_IMPLIES(a_done_has_request, done, $past(start, LAT))
	`GCD_NEVER(a_distance_saturated, done && (distance_cm > HALF_CIRC_CM))
endmodule

// ===== bench/testbench.sv =====
// Testbench for the pipelined haversine distance block: random and directed point pairs.
module testbench;
	import gcd_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int FRAC = ANGLE_FRAC_BITS_DEF;
	localparam int LATENCY = 12 + 2 * STEPS + FRAC;
	localparam int RANDOM_PAIRS = 1680;
	localparam int CALM_TAIL = 200;
	localparam int STALL_LIMIT = 4000;
	localparam logic [63:0] RADIUS_CM = 64'd637100000;

	typedef struct packed {
		logic signed [30:0] lat_a;
		logic signed [31:0] lon_a;
		logic signed [30:0] lat_b;
		logic signed [31:0] lon_b;
	} point_pair_t;

	typedef struct {
		longint c;
		longint s;
	} trig_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [30:0] start_lat;
	logic signed [31:0] start_lon;
	logic signed [30:0] end_lat;
	logic signed [31:0] end_lon;
	logic done;
	logic [30:0] distance_cm;

	point_pair_t pending_pairs[$];
	logic [30:0] expected_dist[$];
	longint arctan_tab[STEPS];
	int total_pairs;
	int pairs_sent;
	int pairs_taken;
	int results_seen;
	int mismatches;
	int gap_left;
	int stall_cycles;
	logic taken;

	great_circle_distance u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_lat(start_lat), .start_lon(start_lon), .end_lat(end_lat), .end_lon(end_lon),
		.done(done), .distance_cm(distance_cm)
	);

	function automatic longint q62_round(logic [63:0] v);
		return longint'((v + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		longint m;
		p = 128'(magnitude(a)) * 128'(magnitude(b));
		p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
		m = longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint units_to_rad(longint d, int extra);
		logic [127:0] p;
		int sh;
		longint m;
		sh = 93 - FRAC + extra;
		p = 128'(magnitude(d)) * 128'(RAD_PER_UNIT_Q93);
		p = (p + (128'd1 << (sh - 1))) >> sh;
		m = longint'(p[63:0]);
		return d < 0 ? -m : m;
	endfunction

	function automatic trig_t rotate_sincos(longint th);
		trig_t r;
		longint half_pi;
		longint pi_f;
		longint x;
		longint y;
		longint nx;
		logic flip;
		half_pi = q62_round(PI_Q62 >> 1);
		pi_f = q62_round(PI_Q62);
		x = q62_round(GAIN_INV_Q62);
		y = 0;
		flip = 1'b0;
		if (th > half_pi) begin
			th = pi_f - th;
			flip = 1'b1;
		end else if (th < -half_pi) begin
			th = -pi_f - th;
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (th >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				th -= arctan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				th += arctan_tab[i];
			end
			x = nx;
		end
		r.c = flip ? -x : x;
		r.s = y;
		return r;
	endfunction

	function automatic longint fixed_sqrt(longint v);
		logic [127:0] target;
		logic [63:0] r;
		logic [63:0] cand;
		target = 128'(v) << FRAC;
		r = '0;
		for (int b = FRAC; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= target)
				r = cand;
		end
		return longint'(r);
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z;
		longint nx;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_tab[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_tab[i];
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic logic [30:0] haversine_cm(point_pair_t p);
		longint dlat;
		longint dlon;
		longint a;
		longint one;
		longint z;
		trig_t t1;
		trig_t t2;
		trig_t th;
		trig_t tn;
		logic [127:0] w;
		dlat = longint'(p.lat_b) - longint'(p.lat_a);
		dlon = (longint'(p.lon_b) - longint'(p.lon_a)) % longint'(FULL_TURN);
		if (dlon > longint'(HALF_TURN))
			dlon -= longint'(FULL_TURN);
		else if (dlon <= -longint'(HALF_TURN))
			dlon += longint'(FULL_TURN);
		t1 = rotate_sincos(units_to_rad(longint'(p.lat_a), 0));
		t2 = rotate_sincos(units_to_rad(longint'(p.lat_b), 0));
		th = rotate_sincos(units_to_rad(dlat, 1));
		tn = rotate_sincos(units_to_rad(dlon, 1));
		a = qmul(th.s, th.s) + qmul(qmul(t1.c, t2.c), qmul(tn.s, tn.s));
		one = longint'(1) << FRAC;
		if (a < 0)
			a = 0;
		if (a > one)
			a = one;
		z = vector_angle(fixed_sqrt(a), fixed_sqrt(one - a));
		if (z < 0)
			z = 0;
		w = 128'(64'(z) * 64'd2) * 128'(RADIUS_CM);
		w = (w + (128'd1 << (FRAC - 1))) >> FRAC;
		if (w > 128'(HALF_CIRC_CM))
			return HALF_CIRC_CM;
		return w[30:0];
	endfunction

	function automatic void fill_arctan();
		logic [63:0] acc;
		logic neg;
		for (int i = 0; i < STEPS; i++) begin
			if (i == 0) begin
				acc = QUARTER_PI_Q62;
			end else begin
				acc = '0;
				neg = 1'b0;
				for (int k = 1; i * k <= 62; k += 2) begin
					acc = neg ? acc - (64'd1 << (62 - i * k)) / 64'(k)
						: acc + (64'd1 << (62 - i * k)) / 64'(k);
					neg = !neg;
				end
			end
			arctan_tab[i] = q62_round(acc);
		end
	endfunction

	function automatic longint rand_lat();
		return longint'($urandom_range(1800000000, 0)) - 900000000;
	endfunction

	function automatic longint rand_lon();
		return longint'($urandom_range(32'd3600000000, 0)) - 1800000000;
	endfunction

	function automatic void add_pair(longint la, longint oa, longint lb, longint ob);
		point_pair_t p;
		p.lat_a = la[30:0];
		p.lon_a = oa[31:0];
		p.lat_b = lb[30:0];
		p.lon_b = ob[31:0];
		pending_pairs.push_back(p);
		total_pairs++;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_pairs.size() > 0 && pairs_sent < total_pairs - CALM_TAIL
					&& $urandom_range(5, 0) == 0) begin
				gap_left <= $urandom_range(3, 0);
				start <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				start <= 1'b1;
				{start_lat, start_lon, end_lat, end_lon} <= pending_pairs.pop_front();
				pairs_sent <= pairs_sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// acceptance, prediction and result check
	always @(posedge clk) begin
		point_pair_t p;
		logic [30:0] want;
		logic got_any;
		logic accept;
		got_any = 1'b0;
		accept = arst_n && start && !busy;
		taken <= accept;
		if (accept) begin
			p = {start_lat, start_lon, end_lat, end_lon};
			expected_dist.push_back(haversine_cm(p));
			pairs_taken <= pairs_taken + 1;
			got_any = 1'b1;
		end
		if (arst_n && done) begin
			got_any = 1'b1;
			results_seen <= results_seen + 1;
			if (expected_dist.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result %0d", distance_cm);
			end else begin
				want = expected_dist.pop_front();
				if (distance_cm !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("distance_cm mismatch: expected %0d, got %0d", want, distance_cm);
				end
			end
		end
		if (arst_n) begin
			stall_cycles <= got_any ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		longint la;
		longint oa;
		start = 1'b0;
		start_lat = '0;
		start_lon = '0;
		end_lat = '0;
		end_lon = '0;
		arst_n = 1'b0;
		taken = 1'b0;
		gap_left = 0;
		total_pairs = 0;
		pairs_sent = 0;
		pairs_taken = 0;
		results_seen = 0;
		mismatches = 0;
		stall_cycles = 0;
		fill_arctan();

		add_pair(0, 0, 0, 0);
		add_pair(123456789, -987654321, 123456789, -987654321);
		add_pair(900000000, 0, -900000000, 0);
		add_pair(900000000, 1800000000, 900000000, -1800000000);
		add_pair(0, 0, 0, 1800000000);
		add_pair(0, -1800000000, 0, 1800000000);
		add_pair(0, 1790000000, 0, -1790000000);
		add_pair(0, -1790000000, 0, 1790000000);
		add_pair(450000000, 0, -450000000, 1800000000);
		add_pair(-900000000, -1800000000, 900000000, 1800000000);
		add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
		add_pair(1073741823, 2147483647, -1073741824, -2147483648);
		add_pair(1073741823, 0, 0, 0);
		add_pair(-1073741824, 100, -1073741824, -2147483648);
		add_pair(1, 0, 0, 1);
		add_pair(0, 1, 0, 0);
		add_pair(899999999, 0, 899999999, 1799999999);
		add_pair(515000000, -1000000, 488566000, 23522000);

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			case ($urandom_range(9, 0))
				0: add_pair(longint'($signed($urandom() >> 1) - 32'sd1073741824),
					longint'($signed($urandom())),
					longint'($signed($urandom() >> 1) - 32'sd1073741824),
					longint'($signed($urandom())));
				1, 2: begin
					la = rand_lat();
					oa = rand_lon();
					add_pair(la, oa, la + $urandom_range(2000, 0) - 1000,
						oa + $urandom_range(2000, 0) - 1000);
				end
				3: begin
					la = rand_lat();
					oa = rand_lon();
					add_pair(la, oa, -la + $urandom_range(20, 0) - 10,
						oa + 1800000000 + $urandom_range(20, 0) - 10);
				end
				default: add_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_pairs.size() == 0 && !start);
		wait (expected_dist.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d point pairs (directed extremes, wrap, antipodes, raw patterns)",
			pairs_taken);
		$display("checked %0d distances, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && expected_dist.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
